>>> src/ckdtf_pkg.sv
// ----------------------------------------------------------------------------
// ckdtf_pkg
// shared types and constants of the ckd track formatter
// ----------------------------------------------------------------------------
package ckdtf_pkg;

    localparam int DATA_RECORDS = 18;
    localparam int RECORD_PAIRS = 64;
    localparam int RIB_PAIRS    = 16;

    localparam int WORD_W = 36;
    localparam int BYTE_W = 8;
    localparam int REP_W  = 13;
    localparam int CYL_W  = 12;
    localparam int HEAD_W = 8;
    localparam int REC_W  = 5;
    localparam int WIR_W  = 7;
    localparam int NIB_W  = 4;
    localparam int TB_W   = 15;
    localparam int CNT_W  = 3;
    localparam int IDX_W  = 2;
    localparam int DLEN_W = 16;

    localparam int CONTENT_BYTES = 5 + 8 + 9 * RIB_PAIRS
                                 + DATA_RECORDS * (8 + 9 * RECORD_PAIRS) + 4;

    localparam logic [TB_W-1:0]   MAX_TRACK   = TB_W'(16384);
    localparam logic [TB_W-1:0]   CONTENT_LEN = TB_W'(CONTENT_BYTES);
    localparam logic [REP_W-1:0]  MAX_REPEAT  = '1;
    localparam logic [DLEN_W-1:0] DLEN_RIB    = DLEN_W'(9 * RIB_PAIRS);
    localparam logic [DLEN_W-1:0] DLEN_REC    = DLEN_W'(9 * RECORD_PAIRS);
    localparam logic [WIR_W-1:0]  RIB_LAST    = WIR_W'(2 * RIB_PAIRS - 1);
    localparam logic [WIR_W-1:0]  REC_LAST    = WIR_W'(2 * RECORD_PAIRS - 1);
    localparam logic [REC_W-1:0]  LAST_RECORD = REC_W'(DATA_RECORDS);
    localparam logic [BYTE_W-1:0] MARK_BYTE   = 8'hff;

    localparam logic [HEAD_W-1:0] HPC_RESET = 8'd19;
    localparam logic [CYL_W-1:0]  CPD_RESET = 12'd800;
    localparam logic [TB_W-1:0]   TB_RESET  = 15'd13312;

    typedef enum logic [1:0] {
        CFG_HEADS = 2'd0,
        CFG_CYLS  = 2'd1,
        CFG_TRACK = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_HA,
        PH_HDR,
        PH_DATA,
        PH_FF,
        PH_FILL
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [NIB_W-1:0]  held;
        logic              odd;
        logic              hdr;
        logic              rec0;
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] hd;
        logic [REC_W-1:0]  rec;
        logic              close;
        logic              disk_wrap;
        logic [TB_W-1:0]   fill;
    } desc_t;

endpackage

>>> src/ckd_track_formatter_36bit.sv
// ----------------------------------------------------------------------------
// ckd_track_formatter_36bit
// packs 36-bit words into a count-key-data track byte stream
// ----------------------------------------------------------------------------
// One result word leaves per clock at most, while m_ready allows, and that
// output rate sets the pace: an input word causes 4 (even word) or 5 (odd
// word) data bytes, plus 8 header bytes at the start of a record (13 at the
// start of record 0), plus 4 marker bytes and the fill results on the word
// that closes a track. A two-entry queue sits between the word intake, which
// keeps the track position and writes the geometry registers, and the byte
// sequencer, so input words are taken while earlier ones are still being
// expanded. Fill runs go out as one result with a repeat count.
module ckd_track_formatter_36bit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ckdtf_pkg::WORD_W-1:0]    s_data_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ckdtf_pkg::BYTE_W-1:0]    m_out_byte,
    output logic [ckdtf_pkg::REP_W-1:0]     m_repeat_count,
    output logic                            m_last_of_item,
    output logic                            m_track_end,
    output logic                            m_disk_end,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [ckdtf_pkg::TB_W-1:0]      cfg_wdata
);

    ckdtf_pkg::desc_t push_desc;
    ckdtf_pkg::desc_t head_desc;
    logic             push;
    logic             full;
    logic             pop;
    logic             head_valid;

    ckdtf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_word (s_data_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_full      (full),
        .q_push      (push),
        .q_desc      (push_desc)
    );

    ckdtf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    ckdtf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_desc      (head_desc),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_repeat_count (m_repeat_count),
        .m_last_of_item (m_last_of_item),
        .m_track_end    (m_track_end),
        .m_disk_end     (m_disk_end)
    );

`ifndef SYNTHESIS
    a_track_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_track_end |-> m_last_of_item)
        else $error("track end not on last word of item");

    a_disk_end_track: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_disk_end |-> m_track_end)
        else $error("disk end without track end");

    a_repeat_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_repeat_count != 13'd1) |->
            (m_out_byte == '0) && (m_repeat_count != '0))
        else $error("repeat count on a non-fill word");

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("descriptor popped from empty queue");
`endif

endmodule

>>> src/ckdtf_front.sv
// ----------------------------------------------------------------------------
// ckdtf_front
// takes words, tracks record/head/cylinder position, builds descriptors
// ----------------------------------------------------------------------------
module ckdtf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ckdtf_pkg::WORD_W-1:0]        s_data_word,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [ckdtf_pkg::TB_W-1:0]          cfg_wdata,
    input  logic                                q_full,
    output logic                                q_push,
    output ckdtf_pkg::desc_t                    q_desc
);

    logic [ckdtf_pkg::HEAD_W-1:0] hpc_reg, hpc_next;
    logic [ckdtf_pkg::CYL_W-1:0]  cpd_reg, cpd_next;
    logic [ckdtf_pkg::TB_W-1:0]   tb_reg, tb_next;
    logic [ckdtf_pkg::CYL_W-1:0]  cyl_reg, cyl_next;
    logic [ckdtf_pkg::HEAD_W-1:0] head_reg, head_next;
    logic [ckdtf_pkg::REC_W-1:0]  rec_reg, rec_next;
    logic [ckdtf_pkg::WIR_W-1:0]  wir_reg, wir_next;
    logic [ckdtf_pkg::NIB_W-1:0]  held_reg, held_next;

    logic                          accept;
    logic                          rec0;
    logic                          odd;
    logic                          last_word;
    logic                          close;
    logic [ckdtf_pkg::HEAD_W:0]    head_inc;
    logic [ckdtf_pkg::CYL_W:0]     cyl_inc;
    logic                          head_wrap;
    logic                          disk_wrap;
    logic [ckdtf_pkg::TB_W-1:0]    tb_clamp;
    logic [ckdtf_pkg::TB_W-1:0]    fill;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    assign rec0      = (rec_reg == '0);
    assign odd       = wir_reg[0];
    assign last_word = (wir_reg == (rec0 ? ckdtf_pkg::RIB_LAST : ckdtf_pkg::REC_LAST));
    assign close     = last_word && (rec_reg >= ckdtf_pkg::LAST_RECORD);
    assign head_inc  = {1'b0, head_reg} + 1'b1;
    assign cyl_inc   = {1'b0, cyl_reg} + 1'b1;
    assign head_wrap = (head_inc >= {1'b0, hpc_reg});
    assign disk_wrap = head_wrap && (cyl_inc >= {1'b0, cpd_reg});
    assign tb_clamp  = (tb_reg > ckdtf_pkg::MAX_TRACK) ? ckdtf_pkg::MAX_TRACK : tb_reg;
    assign fill      = (tb_clamp > ckdtf_pkg::CONTENT_LEN) ?
                       (tb_clamp - ckdtf_pkg::CONTENT_LEN) : '0;

    always_comb begin
        q_desc.data_word = s_data_word;
        q_desc.held      = held_reg;
        q_desc.odd       = odd;
        q_desc.hdr       = (wir_reg == '0);
        q_desc.rec0      = rec0;
        q_desc.cyl       = cyl_reg;
        q_desc.hd        = head_reg;
        q_desc.rec       = rec_reg;
        q_desc.close     = close;
        q_desc.disk_wrap = disk_wrap;
        q_desc.fill      = fill;
    end

    // configuration writes
    always_comb begin
        hpc_next = hpc_reg;
        cpd_next = cpd_reg;
        tb_next  = tb_reg;
        if (cfg_we) begin
            if (cfg_index == ckdtf_pkg::CFG_HEADS) begin
                hpc_next = cfg_wdata[ckdtf_pkg::HEAD_W-1:0];
            end
            if (cfg_index == ckdtf_pkg::CFG_CYLS) begin
                cpd_next = cfg_wdata[ckdtf_pkg::CYL_W-1:0];
            end
            if (cfg_index == ckdtf_pkg::CFG_TRACK) begin
                tb_next = cfg_wdata;
            end
        end
    end

    // track position
    always_comb begin
        cyl_next  = cyl_reg;
        head_next = head_reg;
        rec_next  = rec_reg;
        wir_next  = wir_reg;
        held_next = held_reg;
        if (accept) begin
            held_next = odd ? '0 : s_data_word[ckdtf_pkg::NIB_W-1:0];
            if (last_word) begin
                wir_next = '0;
                if (close) begin
                    rec_next = '0;
                    if (head_wrap) begin
                        head_next = '0;
                        cyl_next  = disk_wrap ? '0 : cyl_inc[ckdtf_pkg::CYL_W-1:0];
                    end else begin
                        head_next = head_inc[ckdtf_pkg::HEAD_W-1:0];
                    end
                end else begin
                    rec_next = rec_reg + 1'b1;
                end
            end else begin
                wir_next = wir_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hpc_reg  <= ckdtf_pkg::HPC_RESET;
            cpd_reg  <= ckdtf_pkg::CPD_RESET;
            tb_reg   <= ckdtf_pkg::TB_RESET;
            cyl_reg  <= '0;
            head_reg <= '0;
            rec_reg  <= '0;
            wir_reg  <= '0;
            held_reg <= '0;
        end else begin
            hpc_reg  <= hpc_next;
            cpd_reg  <= cpd_next;
            tb_reg   <= tb_next;
            cyl_reg  <= cyl_next;
            head_reg <= head_next;
            rec_reg  <= rec_next;
            wir_reg  <= wir_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> src/ckdtf_queue.sv
// ----------------------------------------------------------------------------
// ckdtf_queue
// two-entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module ckdtf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ckdtf_pkg::desc_t push_desc,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ckdtf_pkg::desc_t head_desc
);

    ckdtf_pkg::desc_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/ckdtf_back.sv
// ----------------------------------------------------------------------------
// ckdtf_back
// byte sequencer: expands one descriptor into track bytes, output register
// ----------------------------------------------------------------------------
module ckdtf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  ckdtf_pkg::desc_t                head_desc,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ckdtf_pkg::BYTE_W-1:0]    m_out_byte,
    output logic [ckdtf_pkg::REP_W-1:0]     m_repeat_count,
    output logic                            m_last_of_item,
    output logic                            m_track_end,
    output logic                            m_disk_end
);

    localparam logic [ckdtf_pkg::CNT_W-1:0] HA_LAST   = 3'd4;
    localparam logic [ckdtf_pkg::CNT_W-1:0] HDR_LAST  = 3'd7;
    localparam logic [ckdtf_pkg::CNT_W-1:0] ODD_LAST  = 3'd4;
    localparam logic [ckdtf_pkg::CNT_W-1:0] EVEN_LAST = 3'd3;
    localparam logic [ckdtf_pkg::CNT_W-1:0] FF_LAST   = 3'd3;

    ckdtf_pkg::phase_t              ph_reg, ph_next, eff_ph, first_ph;
    logic [ckdtf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ckdtf_pkg::TB_W-1:0]     left_reg, left_next, left_after;
    logic [ckdtf_pkg::REP_W-1:0]    chunk;
    logic                           out_load;
    logic                           fire;
    logic                           done;
    logic [ckdtf_pkg::DLEN_W-1:0]   dlen;
    logic [ckdtf_pkg::CNT_W-1:0]    data_pos;
    logic [ckdtf_pkg::IDX_W-1:0]    data_idx;
    logic [ckdtf_pkg::BYTE_W-1:0]   cyl_hi;
    logic [ckdtf_pkg::BYTE_W-1:0]   byte_c;
    logic [ckdtf_pkg::REP_W-1:0]    rep_c;

    logic                           m_valid_reg, m_valid_next;
    logic [ckdtf_pkg::BYTE_W-1:0]   byte_reg;
    logic [ckdtf_pkg::REP_W-1:0]    rep_reg;
    logic                           last_reg, tend_reg, dend_reg;

    assign out_load = !m_valid_reg || m_ready;
    assign fire     = head_valid && out_load;
    assign pop      = fire && done;

    assign first_ph = head_desc.hdr ?
                      (head_desc.rec0 ? ckdtf_pkg::PH_HA : ckdtf_pkg::PH_HDR) :
                      ckdtf_pkg::PH_DATA;
    assign eff_ph   = (ph_reg == ckdtf_pkg::PH_START) ? first_ph : ph_reg;

    assign chunk      = (left_reg > {2'b00, ckdtf_pkg::MAX_REPEAT}) ?
                        ckdtf_pkg::MAX_REPEAT : left_reg[ckdtf_pkg::REP_W-1:0];
    assign left_after = left_reg - {2'b00, chunk};

    assign dlen     = head_desc.rec0 ? ckdtf_pkg::DLEN_RIB : ckdtf_pkg::DLEN_REC;
    assign data_pos = cnt_reg - {2'b00, head_desc.odd};
    assign data_idx = data_pos[ckdtf_pkg::IDX_W-1:0];
    assign cyl_hi   = {4'b0000, head_desc.cyl[ckdtf_pkg::CYL_W-1:8]};

    // next state
    always_comb begin
        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        left_next = left_reg;
        done      = 1'b0;
        unique case (eff_ph)
            ckdtf_pkg::PH_HA: begin
                if (cnt_reg == HA_LAST) begin
                    ph_next  = ckdtf_pkg::PH_HDR;
                    cnt_next = '0;
                end else begin
                    ph_next  = ckdtf_pkg::PH_HA;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ckdtf_pkg::PH_HDR: begin
                if (cnt_reg == HDR_LAST) begin
                    ph_next  = ckdtf_pkg::PH_DATA;
                    cnt_next = '0;
                end else begin
                    ph_next  = ckdtf_pkg::PH_HDR;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ckdtf_pkg::PH_DATA: begin
                if (cnt_reg == (head_desc.odd ? ODD_LAST : EVEN_LAST)) begin
                    cnt_next = '0;
                    if (head_desc.close) begin
                        ph_next = ckdtf_pkg::PH_FF;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    ph_next  = ckdtf_pkg::PH_DATA;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ckdtf_pkg::PH_FF: begin
                if (cnt_reg == FF_LAST) begin
                    cnt_next = '0;
                    if (head_desc.fill != '0) begin
                        ph_next   = ckdtf_pkg::PH_FILL;
                        left_next = head_desc.fill;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ckdtf_pkg::PH_FILL: begin
                left_next = left_after;
                if (left_after == '0) begin
                    done = 1'b1;
                end
            end
            default: begin
                ph_next  = ckdtf_pkg::PH_START;
                cnt_next = '0;
            end
        endcase
        if (done) begin
            ph_next  = ckdtf_pkg::PH_START;
            cnt_next = '0;
        end
        if (!fire) begin
            ph_next   = ph_reg;
            cnt_next  = cnt_reg;
            left_next = left_reg;
        end
    end

    // byte selection
    always_comb begin
        byte_c = '0;
        rep_c  = 13'd1;
        unique case (eff_ph)
            ckdtf_pkg::PH_HA: begin
                unique case (cnt_reg)
                    3'd1:    byte_c = cyl_hi;
                    3'd2:    byte_c = head_desc.cyl[7:0];
                    3'd4:    byte_c = head_desc.hd;
                    default: byte_c = '0;
                endcase
            end
            ckdtf_pkg::PH_HDR: begin
                unique case (cnt_reg)
                    3'd0:    byte_c = cyl_hi;
                    3'd1:    byte_c = head_desc.cyl[7:0];
                    3'd3:    byte_c = head_desc.hd;
                    3'd4:    byte_c = ckdtf_pkg::BYTE_W'(head_desc.rec);
                    3'd6:    byte_c = dlen[15:8];
                    3'd7:    byte_c = dlen[7:0];
                    default: byte_c = '0;
                endcase
            end
            ckdtf_pkg::PH_DATA: begin
                if (head_desc.odd && (cnt_reg == '0)) begin
                    byte_c = {head_desc.held, head_desc.data_word[3:0]};
                end else begin
                    unique case (data_idx)
                        2'd0:    byte_c = head_desc.data_word[35:28];
                        2'd1:    byte_c = head_desc.data_word[27:20];
                        2'd2:    byte_c = head_desc.data_word[19:12];
                        default: byte_c = head_desc.data_word[11:4];
                    endcase
                end
            end
            ckdtf_pkg::PH_FF: begin
                byte_c = ckdtf_pkg::MARK_BYTE;
            end
            ckdtf_pkg::PH_FILL: begin
                byte_c = '0;
                rep_c  = chunk;
            end
            default: begin
                byte_c = '0;
            end
        endcase
    end

    assign m_valid_next = out_load ? fire : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= ckdtf_pkg::PH_START;
            cnt_reg     <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ph_reg      <= ph_next;
            cnt_reg     <= cnt_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg <= byte_c;
            rep_reg  <= rep_c;
            last_reg <= done;
            tend_reg <= done && head_desc.close;
            dend_reg <= done && head_desc.close && head_desc.disk_wrap;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_repeat_count = rep_reg;
    assign m_last_of_item = last_reg;
    assign m_track_end    = tend_reg;
    assign m_disk_end     = dend_reg;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the ckd track formatter against a cycle-free predictor of the track
// byte stream: home address, record headers and nibble packing, geometry
// writes between bursts, random words, random stalls on both channels
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_WORDS = 120;
    localparam int CYCLE_LIMIT = TOTAL_WORDS * 1000;
    localparam int SETTLE      = 32;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [ckdtf_pkg::BYTE_W-1:0] data;
        logic [ckdtf_pkg::REP_W-1:0]  rep;
        logic                         last;
        logic                         tend;
        logic                         dend;
    } stream_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [ckdtf_pkg::WORD_W-1:0]   s_data_word = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [ckdtf_pkg::BYTE_W-1:0]   m_out_byte;
    logic [ckdtf_pkg::REP_W-1:0]    m_repeat_count;
    logic                           m_last_of_item;
    logic                           m_track_end;
    logic                           m_disk_end;
    logic                           cfg_we = 1'b0;
    logic [1:0]                     cfg_index = ckdtf_pkg::CFG_HEADS;
    logic [ckdtf_pkg::TB_W-1:0]     cfg_wdata = '0;

    logic [ckdtf_pkg::WORD_W-1:0]   words_to_send[$];
    stream_t                        expected_stream[$];

    // predictor copy of geometry and track position
    logic [ckdtf_pkg::HEAD_W-1:0]   geo_heads = ckdtf_pkg::HPC_RESET;
    logic [ckdtf_pkg::CYL_W-1:0]    geo_cyls = ckdtf_pkg::CPD_RESET;
    logic [ckdtf_pkg::TB_W-1:0]     geo_track_len = ckdtf_pkg::TB_RESET;
    logic [ckdtf_pkg::CYL_W-1:0]    trk_cyl = '0;
    logic [ckdtf_pkg::HEAD_W-1:0]   trk_head = '0;
    logic [ckdtf_pkg::REC_W-1:0]    trk_rec = '0;
    logic [ckdtf_pkg::WIR_W-1:0]    trk_word = '0;
    logic [ckdtf_pkg::NIB_W-1:0]    trk_nib = '0;

    int                  errors = 0;
    int                  results_seen = 0;
    int                  cycles = 0;
    int                  tx_wait = 0;
    int                  rx_wait = 0;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;

    logic [ckdtf_pkg::WORD_W-1:0] corner_words[24] = '{
        36'h0_0000_0000, 36'hF_FFFF_FFFF, 36'h0_0000_000F, 36'hF_FFFF_FFF0,
        36'h8_0000_0000, 36'h0_0000_0001, 36'hA_AAAA_AAAA, 36'h5_5555_5555,
        36'h1_2345_6789, 36'h9_8765_4321, 36'h0_0000_0010, 36'h0_0000_0008,
        36'hF_0000_0000, 36'h0_F000_0000, 36'h0_0FF0_0000, 36'h0_000F_F000,
        36'h0_0000_0FF0, 36'hE_DCBA_9876, 36'h7_FFFF_FFFF, 36'hF_FFFF_FFFE,
        36'h0_0000_0003, 36'hC_0000_000C, 36'h3_1415_9265, 36'h2_7182_8182
    };

    ckd_track_formatter_36bit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_repeat_count (m_repeat_count),
        .m_last_of_item (m_last_of_item),
        .m_track_end    (m_track_end),
        .m_disk_end     (m_disk_end),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int idle_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [ckdtf_pkg::WORD_W-1:0] next_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return ckdtf_pkg::WORD_W'(1) << $urandom_range(0, ckdtf_pkg::WORD_W - 1);
            default: return r[ckdtf_pkg::WORD_W-1:0];
        endcase
    endfunction

    function automatic void add_byte(input logic [ckdtf_pkg::BYTE_W-1:0] b, input int n);
        stream_t e;
        e = '{data: b, rep: ckdtf_pkg::REP_W'(n), last: 1'b0, tend: 1'b0, dend: 1'b0};
        expected_stream.push_back(e);
    endfunction

    function automatic void add_high32(input logic [ckdtf_pkg::WORD_W-1:0] w);
        add_byte(w[35:28], 1);
        add_byte(w[27:20], 1);
        add_byte(w[19:12], 1);
        add_byte(w[11:4], 1);
    endfunction

    // expand one accepted word into the track bytes it releases
    function automatic void format_word(input logic [ckdtf_pkg::WORD_W-1:0] w);
        int unsigned                    pairs;
        int unsigned                    tb;
        int unsigned                    fill;
        int unsigned                    chunk;
        logic [ckdtf_pkg::DLEN_W-1:0]   dlen;
        logic [ckdtf_pkg::CYL_W-1:0]    cyl;
        logic [ckdtf_pkg::HEAD_W-1:0]   hd;
        bit                             head_wrap;
        bit                             disk_wrap;
        int                             tail;
        pairs = (trk_rec == 0) ? ckdtf_pkg::RIB_PAIRS : ckdtf_pkg::RECORD_PAIRS;
        cyl = trk_cyl;
        hd = trk_head;
        if (trk_word == 0) begin
            dlen = ckdtf_pkg::DLEN_W'(pairs * 9);
            if (trk_rec == 0) begin
                add_byte(8'h00, 1);
                add_byte(ckdtf_pkg::BYTE_W'(cyl >> 8), 1);
                add_byte(cyl[7:0], 1);
                add_byte(8'h00, 1);
                add_byte(hd, 1);
            end
            add_byte(ckdtf_pkg::BYTE_W'(cyl >> 8), 1);
            add_byte(cyl[7:0], 1);
            add_byte(8'h00, 1);
            add_byte(hd, 1);
            add_byte(ckdtf_pkg::BYTE_W'(trk_rec), 1);
            add_byte(8'h00, 1);
            add_byte(dlen[15:8], 1);
            add_byte(dlen[7:0], 1);
        end
        if (!trk_word[0]) begin
            add_high32(w);
            trk_nib = w[3:0];
        end else begin
            add_byte({trk_nib, w[3:0]}, 1);
            add_high32(w);
            trk_nib = '0;
        end
        if (int'(trk_word) + 1 >= 2 * pairs) begin
            trk_word = '0;
            trk_rec = trk_rec + 1'b1;
            if (trk_rec > ckdtf_pkg::LAST_RECORD) begin
                tb = 32'((geo_track_len > ckdtf_pkg::MAX_TRACK) ?
                         ckdtf_pkg::MAX_TRACK : geo_track_len);
                fill = (tb > ckdtf_pkg::CONTENT_BYTES) ? tb - ckdtf_pkg::CONTENT_BYTES : 0;
                head_wrap = int'(hd) + 1 >= int'(geo_heads);
                disk_wrap = head_wrap && (int'(cyl) + 1 >= int'(geo_cyls));
                repeat (4) add_byte(ckdtf_pkg::MARK_BYTE, 1);
                while (fill > 0) begin
                    chunk = (fill > ckdtf_pkg::MAX_REPEAT) ? 32'(ckdtf_pkg::MAX_REPEAT) : fill;
                    add_byte(8'h00, int'(chunk));
                    fill -= chunk;
                end
                tail = expected_stream.size() - 1;
                expected_stream[tail].tend = 1'b1;
                expected_stream[tail].dend = disk_wrap;
                trk_rec = '0;
                if (head_wrap) begin
                    trk_head = '0;
                    trk_cyl = disk_wrap ? '0 : cyl + 1'b1;
                end else begin
                    trk_head = hd + 1'b1;
                end
            end
        end else begin
            trk_word = trk_word + 1'b1;
        end
        tail = expected_stream.size() - 1;
        expected_stream[tail].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 40) begin
            $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, results_seen, got, want);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                format_word(s_data_word);
            end
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (words_to_send.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data_word <= words_to_send.pop_front();
                    tx_wait = idle_draw(tx_calm);
                    if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        stream_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stream.size() == 0) begin
                    report_mismatch("unexpected word", 32'(m_out_byte), 0);
                end else begin
                    want = expected_stream.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch("out_byte", 32'(m_out_byte), 32'(want.data));
                    if (m_repeat_count !== want.rep)
                        report_mismatch("repeat_count", 32'(m_repeat_count), 32'(want.rep));
                    if (m_last_of_item !== want.last)
                        report_mismatch("last_of_item", 32'(m_last_of_item), 32'(want.last));
                    if (m_track_end !== want.tend)
                        report_mismatch("track_end", 32'(m_track_end), 32'(want.tend));
                    if (m_disk_end !== want.dend)
                        report_mismatch("disk_end", 32'(m_disk_end), 32'(want.dend));
                end
                results_seen++;
                rx_wait = idle_draw(rx_calm);
                if ($urandom_range(0, 399) == 0) rx_calm = !rx_calm;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic set_reg(input logic [1:0] idx, input logic [ckdtf_pkg::TB_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            ckdtf_pkg::CFG_HEADS: geo_heads = val[ckdtf_pkg::HEAD_W-1:0];
            ckdtf_pkg::CFG_CYLS:  geo_cyls = val[ckdtf_pkg::CYL_W-1:0];
            ckdtf_pkg::CFG_TRACK: geo_track_len = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [ckdtf_pkg::TB_W-1:0] heads,
                             input logic [ckdtf_pkg::TB_W-1:0] cyls,
                             input logic [ckdtf_pkg::TB_W-1:0] len);
        set_reg(ckdtf_pkg::CFG_HEADS, heads);
        set_reg(ckdtf_pkg::CFG_CYLS, cyls);
        set_reg(ckdtf_pkg::CFG_TRACK, len);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic feed(input int n);
        repeat (n) words_to_send.push_back(next_word());
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (words_to_send.size() != 0 || s_valid || expected_stream.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry, corner words first, then a pause until drained
        foreach (corner_words[i]) words_to_send.push_back(corner_words[i]);
        feed(16);
        drain();

        // one head, one cylinder, largest track
        configure(15'd1, 15'd1, 15'd16384);
        feed(16);
        drain();

        // zero geometry, track exactly full
        configure(15'd0, 15'd0, ckdtf_pkg::CONTENT_LEN);
        feed(16);
        drain();

        // upper data bits ignored, track size clamped
        configure(15'h7f01, 15'd2, 15'h7fff);
        feed(16);
        drain();

        // widest geometry, single fill byte
        configure(15'd255, 15'd4095, ckdtf_pkg::CONTENT_LEN + 1'b1);
        feed(16);
        drain();

        // unused index, then geometry change mid-track with an overfull track
        set_reg(CFG_SPARE, 15'h7fff);
        configure(15'd200, 15'd3000, 15'd10000);
        feed(16);
        drain();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
src/ckdtf_pkg.sv
src/ckdtf_front.sv
src/ckdtf_queue.sv
src/ckdtf_back.sv
src/ckd_track_formatter_36bit.sv
dv/testbench.sv
